[rtl/apt_pkg.sv]
package apt_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int COEF_WIDTH = 18;

   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROW0_LINEAR = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROW1_LINEAR = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROW2_LINEAR = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHIFT_X = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHIFT_Y = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHIFT_Z = 3'd5;

   // Load enables of the four pipeline stages.
   typedef struct packed {
      logic mul;
      logic pair;
      logic total;
      logic out;
   } stage_en_type;

endpackage

[rtl/affine_point_transform_core.sv]
// Affine transform of 3D points by a 3x4 matrix held in configuration registers.
// Points arrive on the req_ channel as signed Q16.16 coordinates; each one gives
// exactly one result on the rsp_ channel, in order, with the saturated
// coordinates, a clipped flag and a copy of the last-point mark.
// A transfer happens at a clock edge where valid is high and stall is low.
// The datapath has four register stages: multiply, pairwise add, final add,
// and round with saturation. A point passes through all four in that order
// before it shows on rsp_valid, and one point is taken every cycle while the
// output flows.
// When the receiver stalls, the pipeline fills up behind the held result;
// req_stall rises only once all four stages hold a point.
// The csr_ channel writes one register per transfer and is always ready. It
// must be used only while no point is in flight. Register indexes are, in
// order, row0_linear, row1_linear, row2_linear, shift_x, shift_y, shift_z;
// other indexes are ignored.
// The synchronous reset empties the pipeline and loads the identity matrix
// with zero translation.
module affine_point_transform_core #(
   parameter int COORD_WIDTH = apt_pkg::COORD_WIDTH,
   parameter int COEF_WIDTH = apt_pkg::COEF_WIDTH,
   localparam int RowWidth = 3 * COEF_WIDTH,
   localparam int CsrWidth = (RowWidth > COORD_WIDTH) ? RowWidth : COORD_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [apt_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CsrWidth-1:0]                 csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [COORD_WIDTH-1:0]       req_px,
   input  logic signed [COORD_WIDTH-1:0]       req_py,
   input  logic signed [COORD_WIDTH-1:0]       req_pz,
   input  logic                                req_is_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [COORD_WIDTH-1:0]       rsp_qx,
   output logic signed [COORD_WIDTH-1:0]       rsp_qy,
   output logic signed [COORD_WIDTH-1:0]       rsp_qz,
   output logic                                rsp_clipped,
   output logic                                rsp_end_mark
);

   localparam logic [COEF_WIDTH-1:0] CoefOne = COEF_WIDTH'(1) << (COEF_WIDTH - 2);
   localparam logic [COEF_WIDTH-1:0] CoefZero = '0;

   logic [RowWidth-1:0]           row0_ff;
   logic [RowWidth-1:0]           row1_ff;
   logic [RowWidth-1:0]           row2_ff;
   logic signed [COORD_WIDTH-1:0] shift_x_ff;
   logic signed [COORD_WIDTH-1:0] shift_y_ff;
   logic signed [COORD_WIDTH-1:0] shift_z_ff;
   logic                          csr_write;
   apt_pkg::stage_en_type         en;
   logic                          sat_x;
   logic                          sat_y;
   logic                          sat_z;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         row0_ff <= {CoefZero, CoefZero, CoefOne};
         row1_ff <= {CoefZero, CoefOne, CoefZero};
         row2_ff <= {CoefOne, CoefZero, CoefZero};
         shift_x_ff <= '0;
         shift_y_ff <= '0;
         shift_z_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            apt_pkg::CSR_ROW0_LINEAR: begin
               row0_ff <= csr_wdata[RowWidth-1:0];
            end
            apt_pkg::CSR_ROW1_LINEAR: begin
               row1_ff <= csr_wdata[RowWidth-1:0];
            end
            apt_pkg::CSR_ROW2_LINEAR: begin
               row2_ff <= csr_wdata[RowWidth-1:0];
            end
            apt_pkg::CSR_SHIFT_X: begin
               shift_x_ff <= csr_wdata[COORD_WIDTH-1:0];
            end
            apt_pkg::CSR_SHIFT_Y: begin
               shift_y_ff <= csr_wdata[COORD_WIDTH-1:0];
            end
            apt_pkg::CSR_SHIFT_Z: begin
               shift_z_ff <= csr_wdata[COORD_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   apt_pipe_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_is_last  (req_is_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_end_mark (rsp_end_mark),
      .en           (en)
   );

   apt_row #(
      .COORD_WIDTH (COORD_WIDTH),
      .COEF_WIDTH  (COEF_WIDTH)
   ) u_row_x (
      .clock    (clock),
      .en       (en),
      .coef_row (row0_ff),
      .shift    (shift_x_ff),
      .px       (req_px),
      .py       (req_py),
      .pz       (req_pz),
      .q        (rsp_qx),
      .sat      (sat_x)
   );

   apt_row #(
      .COORD_WIDTH (COORD_WIDTH),
      .COEF_WIDTH  (COEF_WIDTH)
   ) u_row_y (
      .clock    (clock),
      .en       (en),
      .coef_row (row1_ff),
      .shift    (shift_y_ff),
      .px       (req_px),
      .py       (req_py),
      .pz       (req_pz),
      .q        (rsp_qy),
      .sat      (sat_y)
   );

   apt_row #(
      .COORD_WIDTH (COORD_WIDTH),
      .COEF_WIDTH  (COEF_WIDTH)
   ) u_row_z (
      .clock    (clock),
      .en       (en),
      .coef_row (row2_ff),
      .shift    (shift_z_ff),
      .px       (req_px),
      .py       (req_py),
      .pz       (req_pz),
      .q        (rsp_qz),
      .sat      (sat_z)
   );

   assign rsp_clipped = sat_x || sat_y || sat_z;

endmodule

[rtl/apt_pipe_ctrl.sv]
module apt_pipe_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_is_last,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_end_mark,
   output apt_pkg::stage_en_type en
);

   localparam int NumStages = 4;

   logic [NumStages-1:0] valid_ff;
   logic [NumStages-1:0] valid_in;
   logic [NumStages-1:0] last_ff;
   logic [NumStages-1:0] last_in;
   logic [NumStages-1:0] load;

   always_comb begin
      load[NumStages-1] = !valid_ff[NumStages-1] || !rsp_stall;
      for (int i = NumStages - 2; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
      valid_in = valid_ff;
      last_in = last_ff;
      if (load[0]) begin
         valid_in[0] = req_valid;
         last_in[0] = req_is_last;
      end
      for (int i = 1; i < NumStages; i++) begin
         if (load[i]) begin
            valid_in[i] = valid_ff[i-1];
            last_in[i] = last_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
   end

   assign req_stall = !load[0];
   assign rsp_valid = valid_ff[NumStages-1];
   assign rsp_end_mark = last_ff[NumStages-1];
   assign en.mul = load[0];
   assign en.pair = load[1];
   assign en.total = load[2];
   assign en.out = load[3];

`ifndef SYNTH
   // The input side only waits when every stage holds an item and the output is blocked.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff) && rsp_stall)
      else $error("input stalled while the pipeline has room");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted transfer did not enter the first stage");

   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[1] && !load[2]) |=> valid_ff[1] && $stable(last_ff[1]))
      else $error("blocked item left the pair stage");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule

[rtl/apt_row.sv]
module apt_row #(
   parameter int COORD_WIDTH = apt_pkg::COORD_WIDTH,
   parameter int COEF_WIDTH = apt_pkg::COEF_WIDTH
) (
   input  logic                         clock,
   input  apt_pkg::stage_en_type        en,
   input  logic [3*COEF_WIDTH-1:0]      coef_row,
   input  logic signed [COORD_WIDTH-1:0] shift,
   input  logic signed [COORD_WIDTH-1:0] px,
   input  logic signed [COORD_WIDTH-1:0] py,
   input  logic signed [COORD_WIDTH-1:0] pz,
   output logic signed [COORD_WIDTH-1:0] q,
   output logic                         sat
);

   localparam int CoefFrac = COEF_WIDTH - 2;
   localparam int ProdWidth = COORD_WIDTH + COEF_WIDTH;
   localparam int PairWidth = ProdWidth + 1;
   localparam int SumWidth = ProdWidth + 2;
   localparam int ResWidth = SumWidth - CoefFrac;
   localparam int BiasWidth = COORD_WIDTH + CoefFrac;

   logic signed [COEF_WIDTH-1:0] coef_m [3];
   logic signed [ProdWidth-1:0]  prod_in [3];
   logic signed [ProdWidth-1:0]  prod_ff [3];
   logic signed [BiasWidth-1:0]  bias_in;
   logic signed [BiasWidth-1:0]  bias_ff;
   logic signed [PairWidth-1:0]  pair_a_in;
   logic signed [PairWidth-1:0]  pair_a_ff;
   logic signed [PairWidth-1:0]  pair_b_in;
   logic signed [PairWidth-1:0]  pair_b_ff;
   logic signed [SumWidth-1:0]   sum_in;
   logic signed [SumWidth-1:0]   sum_ff;
   logic [ResWidth-1:0]          res;
   logic [ResWidth-COORD_WIDTH:0] res_top;
   logic                         ovf;
   logic signed [COORD_WIDTH-1:0] q_in;
   logic signed [COORD_WIDTH-1:0] q_ff;
   logic                         sat_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         coef_m[k] = coef_row[k*COEF_WIDTH +: COEF_WIDTH];
      end
   end

   assign prod_in[0] = ProdWidth'(px) * ProdWidth'(coef_m[0]);
   assign prod_in[1] = ProdWidth'(py) * ProdWidth'(coef_m[1]);
   assign prod_in[2] = ProdWidth'(pz) * ProdWidth'(coef_m[2]);

   // Translation in product scale plus half an LSB; its low bits are zero, so no adder.
   assign bias_in = {shift, 1'b1, {(CoefFrac-1){1'b0}}};

   assign pair_a_in = PairWidth'(prod_ff[0]) + PairWidth'(prod_ff[1]);
   assign pair_b_in = PairWidth'(prod_ff[2]) + PairWidth'(bias_ff);

   assign sum_in = SumWidth'(pair_a_ff) + SumWidth'(pair_b_ff);

   assign res = sum_ff[SumWidth-1:CoefFrac];
   assign res_top = res[ResWidth-1:COORD_WIDTH-1];
   assign ovf = (|res_top) && !(&res_top);

   always_comb begin
      if (!ovf) begin
         q_in = res[COORD_WIDTH-1:0];
      end else if (res[ResWidth-1]) begin
         q_in = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
         q_in = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (en.mul) begin
         prod_ff <= prod_in;
         bias_ff <= bias_in;
      end
      if (en.pair) begin
         pair_a_ff <= pair_a_in;
         pair_b_ff <= pair_b_in;
      end
      if (en.total) begin
         sum_ff <= sum_in;
      end
      if (en.out) begin
         q_ff <= q_in;
         sat_ff <= ovf;
      end
   end

   assign q = q_ff;
   assign sat = sat_ff;

endmodule

[dv/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_WIDTH = apt_pkg::COORD_WIDTH;
   localparam int COEF_WIDTH = apt_pkg::COEF_WIDTH;
   localparam int CSR_INDEX_WIDTH = apt_pkg::CSR_INDEX_WIDTH;

   localparam int COEF_FRAC = COEF_WIDTH - 2;
   localparam int ROW_WIDTH = 3 * COEF_WIDTH;
   localparam int CSR_DATA_WIDTH = (ROW_WIDTH > COORD_WIDTH) ? ROW_WIDTH : COORD_WIDTH;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_HI = 3'd7;

   localparam int NUM_PHASES = 8;
   localparam int PHASE_ITEMS = 117;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT = 600000;
   localparam int MAX_REPORTS = 40;

   localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
   localparam logic signed [COEF_WIDTH-1:0] COEF_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
   localparam logic signed [COEF_WIDTH-1:0] COEF_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};
   localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << COEF_FRAC;
   localparam logic signed [COEF_WIDTH-1:0] COEF_HALF = COEF_WIDTH'(1) << (COEF_FRAC - 1);
   localparam logic signed [COEF_WIDTH-1:0] COEF_NEG_LSB = '1;

   typedef enum int {STYLE_FULL, STYLE_SMALL, STYLE_EXTREME, STYLE_MIXED} cfg_style_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] z;
      logic                          last;
   } point_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] qx;
      logic signed [COORD_WIDTH-1:0] qy;
      logic signed [COORD_WIDTH-1:0] qz;
      logic                          clipped;
      logic                          end_mark;
   } xform_type;

   typedef struct {
      logic                       is_write;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [CSR_DATA_WIDTH-1:0]  wdata;
      point_type                  pt;
      logic                       known;
      xform_type                  want;
   } step_type;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]    csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]     csr_wdata = '0;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [COORD_WIDTH-1:0] req_px = '0;
   logic signed [COORD_WIDTH-1:0] req_py = '0;
   logic signed [COORD_WIDTH-1:0] req_pz = '0;
   logic                          req_is_last = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [COORD_WIDTH-1:0] rsp_qx;
   logic signed [COORD_WIDTH-1:0] rsp_qy;
   logic signed [COORD_WIDTH-1:0] rsp_qz;
   logic                          rsp_clipped;
   logic                          rsp_end_mark;

   logic [ROW_WIDTH-1:0]          coef_row [3];
   logic signed [COORD_WIDTH-1:0] shift_row [3];
   xform_type                     pending_xforms [$];
   step_type                      directed_steps [$];
   int                            mismatch_count = 0;
   int                            cycle_count = 0;

   affine_point_transform_core u_dut (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_px       (req_px),
      .req_py       (req_py),
      .req_pz       (req_pz),
      .req_is_last  (req_is_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_qx       (rsp_qx),
      .rsp_qy       (rsp_qy),
      .rsp_qz       (rsp_qz),
      .rsp_clipped  (rsp_clipped),
      .rsp_end_mark (rsp_end_mark)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic xform_type predict_xform(point_type p);
      longint                        acc;
      longint                        lim_hi;
      longint                        lim_lo;
      logic signed [COEF_WIDTH-1:0]  c0;
      logic signed [COEF_WIDTH-1:0]  c1;
      logic signed [COEF_WIDTH-1:0]  c2;
      logic signed [COORD_WIDTH-1:0] q [3];
      xform_type                     r;
      int                            row;
      lim_hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
      lim_lo = -lim_hi - 1;
      r.clipped = 1'b0;
      for (row = 0; row < 3; row++) begin
         c0 = coef_row[row][COEF_WIDTH-1:0];
         c1 = coef_row[row][2*COEF_WIDTH-1:COEF_WIDTH];
         c2 = coef_row[row][3*COEF_WIDTH-1:2*COEF_WIDTH];
         acc = longint'($signed(p.x)) * longint'(c0) + longint'($signed(p.y)) * longint'(c1)
               + longint'($signed(p.z)) * longint'(c2);
         acc = acc + (longint'(shift_row[row]) <<< COEF_FRAC)
               + (longint'(1) <<< (COEF_FRAC - 1));
         acc = acc >>> COEF_FRAC;
         if (acc > lim_hi) begin
            acc = lim_hi;
            r.clipped = 1'b1;
         end else if (acc < lim_lo) begin
            acc = lim_lo;
            r.clipped = 1'b1;
         end
         q[row] = acc[COORD_WIDTH-1:0];
      end
      r.qx = q[0];
      r.qy = q[1];
      r.qz = q[2];
      r.end_mark = p.last;
      return r;
   endfunction

   function automatic logic [COEF_WIDTH-1:0] pick_coef(cfg_style_type style);
      logic [COEF_WIDTH-1:0] c;
      if (style == STYLE_MIXED) begin
         style = cfg_style_type'($urandom_range(0, 2));
      end
      case (style)
         STYLE_SMALL: begin
            c = COEF_WIDTH'(int'($urandom_range(0, 2 * int'(COEF_ONE))) - int'(COEF_ONE));
         end
         STYLE_EXTREME: begin
            case ($urandom_range(0, 4))
               0: c = COEF_MAX;
               1: c = COEF_MIN;
               2: c = '0;
               3: c = COEF_ONE;
               default: c = -COEF_ONE;
            endcase
         end
         default: c = COEF_WIDTH'($urandom);
      endcase
      return c;
   endfunction

   function automatic logic [COORD_WIDTH-1:0] pick_shift(cfg_style_type style);
      logic [COORD_WIDTH-1:0] s;
      if (style == STYLE_MIXED) begin
         style = cfg_style_type'($urandom_range(0, 2));
      end
      case (style)
         STYLE_SMALL: s = COORD_WIDTH'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
         STYLE_EXTREME: begin
            case ($urandom_range(0, 4))
               0: s = COORD_MAX;
               1: s = COORD_MIN;
               2: s = '0;
               3: s = COORD_WIDTH'(1);
               default: s = '1;
            endcase
         end
         default: s = COORD_WIDTH'($urandom);
      endcase
      return s;
   endfunction

   function automatic logic [COORD_WIDTH-1:0] pick_coord();
      int                     roll;
      logic [COORD_WIDTH-1:0] v;
      roll = $urandom_range(0, 9);
      if (roll < 4) begin
         v = COORD_WIDTH'($urandom);
      end else if (roll < 8) begin
         v = COORD_WIDTH'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
      end else begin
         case ($urandom_range(0, 4))
            0: v = COORD_MAX;
            1: v = COORD_MIN;
            2: v = '0;
            3: v = COORD_WIDTH'(1);
            default: v = '1;
         endcase
      end
      return v;
   endfunction

   // Bits above the shift width carry junk that the block must drop.
   function automatic logic [CSR_DATA_WIDTH-1:0] shift_wdata(logic [COORD_WIDTH-1:0] s);
      logic [63:0]               junk;
      logic [CSR_DATA_WIDTH-1:0] d;
      junk = {$urandom, $urandom};
      d = junk[CSR_DATA_WIDTH-1:0];
      d[COORD_WIDTH-1:0] = s;
      return d;
   endfunction

   function automatic int gap_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   task automatic add_write(logic [CSR_INDEX_WIDTH-1:0] index, logic [CSR_DATA_WIDTH-1:0] d);
      step_type s;
      s = '{default: '0};
      s.is_write = 1'b1;
      s.index = index;
      s.wdata = d;
      directed_steps.push_back(s);
   endtask

   task automatic add_point(logic [COORD_WIDTH-1:0] x, logic [COORD_WIDTH-1:0] y,
                            logic [COORD_WIDTH-1:0] z, logic last);
      step_type s;
      s = '{default: '0};
      s.pt = '{x: x, y: y, z: z, last: last};
      directed_steps.push_back(s);
   endtask

   task automatic add_known(logic [COORD_WIDTH-1:0] x, logic [COORD_WIDTH-1:0] y,
                            logic [COORD_WIDTH-1:0] z, logic last,
                            logic [COORD_WIDTH-1:0] qx, logic [COORD_WIDTH-1:0] qy,
                            logic [COORD_WIDTH-1:0] qz, logic clipped);
      step_type s;
      s = '{default: '0};
      s.pt = '{x: x, y: y, z: z, last: last};
      s.known = 1'b1;
      s.want = '{qx: qx, qy: qy, qz: qz, clipped: clipped, end_mark: last};
      directed_steps.push_back(s);
   endtask

   task automatic report_mismatch(string what, logic [COORD_WIDTH-1:0] got,
                                  logic [COORD_WIDTH-1:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("mismatch %s: got %h expected %h (cycle %0d)", what, got, want, cycle_count);
      end
   endtask

   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] index, logic [CSR_DATA_WIDTH-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         apt_pkg::CSR_ROW0_LINEAR: coef_row[0] = d[ROW_WIDTH-1:0];
         apt_pkg::CSR_ROW1_LINEAR: coef_row[1] = d[ROW_WIDTH-1:0];
         apt_pkg::CSR_ROW2_LINEAR: coef_row[2] = d[ROW_WIDTH-1:0];
         apt_pkg::CSR_SHIFT_X: shift_row[0] = d[COORD_WIDTH-1:0];
         apt_pkg::CSR_SHIFT_Y: shift_row[1] = d[COORD_WIDTH-1:0];
         apt_pkg::CSR_SHIFT_Z: shift_row[2] = d[COORD_WIDTH-1:0];
         default: ;
      endcase
   endtask

   task automatic configure_phase(cfg_style_type style);
      write_reg(apt_pkg::CSR_ROW0_LINEAR,
                {pick_coef(style), pick_coef(style), pick_coef(style)});
      write_reg(apt_pkg::CSR_ROW1_LINEAR,
                {pick_coef(style), pick_coef(style), pick_coef(style)});
      write_reg(apt_pkg::CSR_ROW2_LINEAR,
                {pick_coef(style), pick_coef(style), pick_coef(style)});
      write_reg(apt_pkg::CSR_SHIFT_X, shift_wdata(pick_shift(style)));
      write_reg(apt_pkg::CSR_SHIFT_Y, shift_wdata(pick_shift(style)));
      write_reg(apt_pkg::CSR_SHIFT_Z, shift_wdata(pick_shift(style)));
      if ($urandom_range(0, 1)) begin
         write_reg($urandom_range(0, 1) ? CSR_UNUSED_LO : CSR_UNUSED_HI,
                   shift_wdata(COORD_WIDTH'($urandom)));
      end
      csr_valid <= 1'b0;
   endtask

   task automatic send_point(point_type p, xform_type want);
      req_valid <= 1'b1;
      req_px <= p.x;
      req_py <= p.y;
      req_pz <= p.z;
      req_is_last <= p.last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_xforms.push_back(want);
   endtask

   task automatic idle_sender(int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_xforms.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int         hold;
      int         roll;
      logic       stalling;
      hold = 0;
      stalling = 1'b0;
      forever begin
         @(posedge clock);
         if (hold == 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
               stalling = 1'b0;
               hold = $urandom_range(1, 6);
            end else if (roll < 80) begin
               stalling = 1'b1;
               hold = $urandom_range(1, 3);
            end else if (roll < 90) begin
               stalling = 1'b0;
               hold = $urandom_range(50, 200);
            end else begin
               stalling = 1'b1;
               hold = $urandom_range(10, 40);
            end
         end
         hold--;
         rsp_stall <= stalling;
      end
   end

   always @(posedge clock) begin
      xform_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_xforms.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_qx, '0);
         end else begin
            want = pending_xforms.pop_front();
            if (rsp_qx !== want.qx) report_mismatch("qx", rsp_qx, want.qx);
            if (rsp_qy !== want.qy) report_mismatch("qy", rsp_qy, want.qy);
            if (rsp_qz !== want.qz) report_mismatch("qz", rsp_qz, want.qz);
            if (rsp_clipped !== want.clipped) begin
               report_mismatch("clipped", COORD_WIDTH'(rsp_clipped), COORD_WIDTH'(want.clipped));
            end
            if (rsp_end_mark !== want.end_mark) begin
               report_mismatch("end_mark", COORD_WIDTH'(rsp_end_mark),
                               COORD_WIDTH'(want.end_mark));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[affine_point_transform_core] ERROR");
         $finish;
      end
   end

   initial begin
      logic          writing;
      point_type     pt;
      cfg_style_type style;
      logic          no_gaps;
      int            phase;
      int            item;

      coef_row[0] = ROW_WIDTH'(1) << COEF_FRAC;
      coef_row[1] = ROW_WIDTH'(1) << (COEF_WIDTH + COEF_FRAC);
      coef_row[2] = ROW_WIDTH'(1) << (2 * COEF_WIDTH + COEF_FRAC);
      shift_row[0] = '0;
      shift_row[1] = '0;
      shift_row[2] = '0;

      // The identity matrix after reset passes every point through unchanged.
      add_known('0, '0, '0, 1'b0, '0, '0, '0, 1'b0);
      add_known(COORD_MAX, COORD_MIN, 1, 1'b1, COORD_MAX, COORD_MIN, 1, 1'b0);
      add_known(COORD_MIN, COORD_MAX, '1, 1'b0, COORD_MIN, COORD_MAX, '1, 1'b0);
      add_known(32'h5a5a_a5a5, 32'ha5a5_5a5a, 32'h0001_0000, 1'b1,
                32'h5a5a_a5a5, 32'ha5a5_5a5a, 32'h0001_0000, 1'b0);
      // Translations at the limits: one step beyond them saturates.
      add_write(apt_pkg::CSR_SHIFT_X, shift_wdata(COORD_MAX));
      add_write(apt_pkg::CSR_SHIFT_Y, shift_wdata(COORD_MIN));
      add_write(apt_pkg::CSR_SHIFT_Z, shift_wdata(1));
      add_known(1, '0, '0, 1'b0, COORD_MAX, COORD_MIN, 1, 1'b1);
      add_known('0, '0, -2, 1'b1, COORD_MAX, COORD_MIN, '1, 1'b0);
      add_known('0, '1, '0, 1'b0, COORD_MAX, COORD_MIN, 1, 1'b1);
      // Extreme coefficients, a half-step row for rounding ties, ignored indexes.
      add_write(apt_pkg::CSR_ROW0_LINEAR, {{COEF_WIDTH{1'b0}}, COEF_MIN, COEF_MAX});
      add_write(apt_pkg::CSR_ROW1_LINEAR, {COEF_NEG_LSB, COEF_NEG_LSB, COEF_NEG_LSB});
      add_write(apt_pkg::CSR_ROW2_LINEAR,
                {COEF_HALF, {COEF_WIDTH{1'b0}}, {COEF_WIDTH{1'b0}}});
      add_write(apt_pkg::CSR_SHIFT_X, shift_wdata('0));
      add_write(apt_pkg::CSR_SHIFT_Y, shift_wdata('0));
      add_write(apt_pkg::CSR_SHIFT_Z, shift_wdata('0));
      add_write(CSR_UNUSED_LO, '1);
      add_write(CSR_UNUSED_HI, shift_wdata(COORD_WIDTH'($urandom)));
      add_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
      add_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
      add_point(COORD_MIN, COORD_MAX, '0, 1'b0);
      add_point(COORD_MAX, COORD_MIN, 1, 1'b0);
      add_point('0, '0, 1, 1'b0);
      add_point('0, '0, '1, 1'b0);
      add_point('0, '0, 3, 1'b0);
      add_point('0, '0, -3, 1'b0);
      add_point(1, 1, 1, 1'b1);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      writing = 1'b0;
      foreach (directed_steps[i]) begin
         if (directed_steps[i].is_write) begin
            if (!writing) begin
               wait_drained();
            end
            write_reg(directed_steps[i].index, directed_steps[i].wdata);
            writing = 1'b1;
         end else begin
            if (writing) begin
               csr_valid <= 1'b0;
            end
            writing = 1'b0;
            pt = directed_steps[i].pt;
            send_point(pt, directed_steps[i].known ? directed_steps[i].want
                                                    : predict_xform(pt));
            idle_sender(gap_len());
         end
      end

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         style = cfg_style_type'(phase % 4);
         wait_drained();
         configure_phase(style);
         no_gaps = (phase % 3 == 1);
         for (item = 0; item < PHASE_ITEMS; item++) begin
            pt.x = pick_coord();
            pt.y = pick_coord();
            pt.z = pick_coord();
            pt.last = ($urandom_range(0, 7) == 0) || (item == PHASE_ITEMS - 1);
            send_point(pt, predict_xform(pt));
            if (item == PHASE_ITEMS / 2) begin
               wait_drained();
            end else if (!no_gaps) begin
               idle_sender(gap_len());
            end
         end
      end

      wait_drained();
      if (mismatch_count == 0) begin
         $display("[affine_point_transform_core] OK");
      end else begin
         $display("[affine_point_transform_core] ERROR");
      end
      $finish;
   end

endmodule
